### rtl/dr3d_pkg.sv
// Shared types, constants and the divide-step function for the disparity reprojection core.
// Depends on nothing; every other file in rtl/ imports it.
package dr3d_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_FOCAL     = 3'd0;
  localparam logic [2:0] REG_BASELINE  = 3'd1;
  localparam logic [2:0] REG_U0        = 3'd2;
  localparam logic [2:0] REG_V0        = 3'd3;
  localparam logic [2:0] REG_MIN_DISP  = 3'd4;
  localparam logic [2:0] REG_DEPTH_LIM = 3'd5;

  localparam int IDX_W  = 3;
  localparam int CFG_W  = 24;

  // Reset values of the calibration registers
  localparam logic [15:0] FOCAL_RST     = 16'd10520;
  localparam logic [19:0] BASELINE_RST  = 20'd19661;
  localparam logic [15:0] U0_RST        = 16'd8152;
  localparam logic [15:0] V0_RST        = 16'd3954;
  localparam logic [15:0] MIN_DISP_RST  = 16'd16;
  localparam logic [23:0] DEPTH_LIM_RST = 24'd1966080;

  // Numerator / quotient width: 16-bit magnitude times 20-bit baseline
  localparam int QW              = 36;
  localparam int STEPS_PER_STAGE = 2;
  localparam int NDIV            = QW / STEPS_PER_STAGE;
  // front (2) + divider stages + output register
  localparam int NST             = NDIV + 3;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic        sx;    // column offset negative
    logic        sy;    // row offset negative
    logic        pass;  // coordinate range and disparity minimum met
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [15:0]    d;
    logic [QW-1:0]  nx;
    logic [QW-1:0]  ny;
    logic [QW-1:0]  nz;
  } div_in_t;

  typedef struct packed {
    side_t          side;
    logic [QW-1:0]  qx;
    logic [QW-1:0]  qy;
    logic [QW-1:0]  qz;
  } div_out_t;

  // One lane of a restoring divider: remainder plus a word that holds the
  // unconsumed numerator bits on top and the quotient bits below.
  typedef struct packed {
    logic [15:0]   rem;
    logic [QW-1:0] nq;
  } div_lane_t;

  function automatic div_lane_t div_stage(div_lane_t cur, logic [15:0] den);
    div_lane_t   res;
    logic [16:0] part;
    res = cur;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      part   = {res.rem, res.nq[QW-1]};
      res.nq = {res.nq[QW-2:0], 1'b0};
      if (part >= {1'b0, den}) begin
        part      = part - {1'b0, den};
        res.nq[0] = 1'b1;
      end
      res.rem = part[15:0];
    end
    return res;
  endfunction

endpackage

### rtl/dr3d_pipe.sv
// Valid chain and per-stage load enables for the reprojection pipeline.
// Depends on dr3d_pkg for the stage count.
module dr3d_pipe import dr3d_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_stall,
  input  logic           keep,
  output logic [NST-1:0] en,
  output logic           out_valid,
  output logic           in_stall
);

  logic [NST-1:0] vld;

  // A stage loads when it is empty or its word moves on; bubbles collapse.
  assign en[NST-1] = !vld[NST-1] || !out_stall;

  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NST - 1; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
      // drop rejected pixels at the output register
      if (en[NST-1]) vld[NST-1] <= vld[NST-2] && keep;
    end
  end

  assign out_valid = vld[NST-1];
  assign in_stall  = !en[0];

endmodule

### rtl/dr3d_front.sv
// Front stages: pixel offsets and range checks, then the three numerator products.
// Depends on dr3d_pkg.
module dr3d_front import dr3d_pkg::*; #(
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096
) (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [11:0] pixel_row,
  input  logic [11:0] pixel_col,
  input  logic [15:0] disparity_q4,
  input  logic [15:0] focal_q4,
  input  logic [19:0] baseline_q16,
  input  logic [15:0] u0_q4,
  input  logic [15:0] v0_q4,
  input  logic [15:0] min_disparity_q4,
  output div_in_t     div_in
);

  localparam logic [16:0] ROW_LIM = 17'(MAX_ROWS);
  localparam logic [16:0] COL_LIM = 17'(MAX_COLS);

  logic [16:0] offx;
  logic [16:0] offy;
  logic [16:0] negx;
  logic [16:0] negy;
  logic        pass0;

  side_t       s0_side;
  logic [15:0] s0_d;
  logic [15:0] s0_magx;
  logic [15:0] s0_magy;

  assign offx  = {1'b0, pixel_col, 4'b0000} - {1'b0, u0_q4};
  assign offy  = {1'b0, pixel_row, 4'b0000} - {1'b0, v0_q4};
  assign negx  = 17'd0 - offx;
  assign negy  = 17'd0 - offy;
  assign pass0 = ({5'b0, pixel_row} < ROW_LIM) && ({5'b0, pixel_col} < COL_LIM) &&
                 (disparity_q4 > min_disparity_q4);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_side.row  <= pixel_row;
      s0_side.col  <= pixel_col;
      s0_side.sx   <= offx[16];
      s0_side.sy   <= offy[16];
      s0_side.pass <= pass0;
      s0_d         <= disparity_q4;
      s0_magx      <= offx[16] ? negx[15:0] : offx[15:0];
      s0_magy      <= offy[16] ? negy[15:0] : offy[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      div_in.side <= s0_side;
      div_in.d    <= s0_d;
      div_in.nx   <= {20'b0, s0_magx} * {16'b0, baseline_q16};
      div_in.ny   <= {20'b0, s0_magy} * {16'b0, baseline_q16};
      div_in.nz   <= {16'b0, baseline_q16} * {20'b0, focal_q4};
    end
  end

endmodule

### rtl/dr3d_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, two quotient bits a stage.
// Depends on dr3d_pkg for div_stage and the stage types.
module dr3d_div import dr3d_pkg::*; (
  input  logic            clk,
  input  logic [NDIV-1:0] en,
  input  div_in_t         div_in,
  output div_out_t        div_out
);

  side_t       sb [NDIV];
  logic [15:0] dd [NDIV];
  div_lane_t   lx [NDIV];
  div_lane_t   ly [NDIV];
  div_lane_t   lz [NDIV];

  for (genvar k = 0; k < NDIV; k++) begin : g_stage
    side_t       side_in;
    logic [15:0] d_in;
    div_lane_t   lx_in;
    div_lane_t   ly_in;
    div_lane_t   lz_in;

    if (k == 0) begin : g_first
      assign side_in = div_in.side;
      assign d_in    = div_in.d;
      assign lx_in   = '{rem: 16'd0, nq: div_in.nx};
      assign ly_in   = '{rem: 16'd0, nq: div_in.ny};
      assign lz_in   = '{rem: 16'd0, nq: div_in.nz};
    end else begin : g_next
      assign side_in = sb[k-1];
      assign d_in    = dd[k-1];
      assign lx_in   = lx[k-1];
      assign ly_in   = ly[k-1];
      assign lz_in   = lz[k-1];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        sb[k] <= side_in;
        dd[k] <= d_in;
        lx[k] <= div_stage(lx_in, d_in);
        ly[k] <= div_stage(ly_in, d_in);
        lz[k] <= div_stage(lz_in, d_in);
      end
    end
  end

  assign div_out.side = sb[NDIV-1];
  assign div_out.qx   = lx[NDIV-1].nq;
  assign div_out.qy   = ly[NDIV-1].nq;
  assign div_out.qz   = lz[NDIV-1].nq;

endmodule

### rtl/dr3d_back.sv
// Output stage: sign the quotients, apply the depth limit, hold the result word.
// Depends on dr3d_pkg.
module dr3d_back import dr3d_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  div_out_t    div_out,
  input  logic [23:0] depth_limit_q16,
  output logic        keep,
  output logic [47:0] point_x,
  output logic [47:0] point_y,
  output logic [24:0] point_z,
  output logic [11:0] out_row,
  output logic [11:0] out_col
);

  logic [47:0] qx_ext;
  logic [47:0] qy_ext;

  assign qx_ext = {12'b0, div_out.qx};
  assign qy_ext = {12'b0, div_out.qy};
  assign keep   = div_out.side.pass && (div_out.qz < {12'b0, depth_limit_q16});

  always_ff @(posedge clk) begin
    if (en) begin
      // x follows the column offset sign, y is flipped so up is positive
      point_x <= div_out.side.sx ? (48'd0 - qx_ext) : qx_ext;
      point_y <= div_out.side.sy ? qy_ext : (48'd0 - qy_ext);
      point_z <= 25'd0 - {1'b0, div_out.qz[23:0]};
      out_row <= div_out.side.row;
      out_col <= div_out.side.col;
    end
  end

endmodule

### rtl/disparity_to_3d_reprojection_core.sv
// Top level of the stereo disparity reprojection core.
// Depends on dr3d_pkg, dr3d_pipe, dr3d_front, dr3d_div and dr3d_back.
//
// Usage:
//   Input channel: one word per pixel (pixel_row, pixel_col, disparity_q4),
//   taken on a rising edge with in_valid high and in_stall low. Output channel:
//   one word per kept pixel (point_x/y/z in signed Q16 meters, out_row, out_col),
//   taken on a rising edge with out_valid high and out_stall low.
//   A pixel is kept when it lies inside MAX_ROWS x MAX_COLS, its disparity is
//   above min_disparity_q4 and its depth magnitude is below depth_limit_q16;
//   any other pixel leaves no word at all.
// Throughput: one pixel per cycle, sustained with no gaps while out_stall stays low.
// Pipeline depth: 21 register stages, set mostly by the divider, which
//   resolves two quotient bits per stage over a 36-bit quotient (18 stages),
//   behind an offset stage and a multiply stage and ahead of the output register.
// Stall: when out_stall holds the output word, the stages behind it fill up
//   first; empty stages keep moving, and in_stall rises only once every stage
//   holds a word. Nothing is lost or repeated.
// Reset (rst, synchronous): empties the pipeline and loads the calibration
//   defaults. Write registers over cfg_wr_en/cfg_index/cfg_data only while no
//   pixel is in flight; unknown indexes are ignored.
module disparity_to_3d_reprojection_core import dr3d_pkg::*; #(
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [11:0]      pixel_row,
  input  logic [11:0]      pixel_col,
  input  logic [15:0]      disparity_q4,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [47:0]      point_x,
  output logic [47:0]      point_y,
  output logic [24:0]      point_z,
  output logic [11:0]      out_row,
  output logic [11:0]      out_col
);

  logic [15:0] focal_q4;
  logic [19:0] baseline_q16;
  logic [15:0] u0_q4;
  logic [15:0] v0_q4;
  logic [15:0] min_disparity_q4;
  logic [23:0] depth_limit_q16;

  logic [NST-1:0] en;
  logic           keep;
  div_in_t        div_in;
  div_out_t       div_out;

  // Calibration registers; values are cut to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_q4         <= FOCAL_RST;
      baseline_q16     <= BASELINE_RST;
      u0_q4            <= U0_RST;
      v0_q4            <= V0_RST;
      min_disparity_q4 <= MIN_DISP_RST;
      depth_limit_q16  <= DEPTH_LIM_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FOCAL:     focal_q4         <= cfg_data[15:0];
        REG_BASELINE:  baseline_q16     <= cfg_data[19:0];
        REG_U0:        u0_q4            <= cfg_data[15:0];
        REG_V0:        v0_q4            <= cfg_data[15:0];
        REG_MIN_DISP:  min_disparity_q4 <= cfg_data[15:0];
        REG_DEPTH_LIM: depth_limit_q16  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage load enables
  dr3d_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .keep      (keep),
    .en        (en),
    .out_valid (out_valid),
    .in_stall  (in_stall)
  );

  // Offsets, range checks and numerator products
  dr3d_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk              (clk),
    .en               (en[1:0]),
    .pixel_row        (pixel_row),
    .pixel_col        (pixel_col),
    .disparity_q4     (disparity_q4),
    .focal_q4         (focal_q4),
    .baseline_q16     (baseline_q16),
    .u0_q4            (u0_q4),
    .v0_q4            (v0_q4),
    .min_disparity_q4 (min_disparity_q4),
    .div_in           (div_in)
  );

  // Divide all three numerators by the disparity
  dr3d_div u_div (
    .clk     (clk),
    .en      (en[NDIV+1:2]),
    .div_in  (div_in),
    .div_out (div_out)
  );

  // Sign, depth limit and output word
  dr3d_back u_back (
    .clk             (clk),
    .en              (en[NST-1]),
    .div_out         (div_out),
    .depth_limit_q16 (depth_limit_q16),
    .keep            (keep),
    .point_x         (point_x),
    .point_y         (point_y),
    .point_z         (point_z),
    .out_row         (out_row),
    .out_col         (out_col)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for disparity_to_3d_reprojection_core: directed and random pixels under
// several calibrations, each output word checked against a built-in reprojection predictor.
// Depends on dr3d_pkg and the core RTL; reads no files.
module tb import dr3d_pkg::*; ();

  // Image size as configured on the core instance (parameter defaults).
  localparam int IMG_ROWS = 4096;
  localparam int IMG_COLS = 4096;
  // The core holds a pixel in 21 register stages; the drain wait leaves margin beyond that depth.
  localparam int PIPE_DRAIN = 30;
  localparam int CYCLE_LIMIT = 500000;
  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [15:0] disp;
  } pixel_t;

  typedef struct packed {
    logic [47:0] x;
    logic [47:0] y;
    logic [24:0] z;
    logic [11:0] row;
    logic [11:0] col;
  } point_t;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_TOGGLE, STALL_HEAVY} stall_mode_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_FOCAL;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [11:0]      pixel_row = '0;
  logic [11:0]      pixel_col = '0;
  logic [15:0]      disparity_q4 = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [47:0]      point_x;
  logic [47:0]      point_y;
  logic [24:0]      point_z;
  logic [11:0]      out_row;
  logic [11:0]      out_col;

  // Calibration as the core should hold it; changed only while the core is idle.
  logic [15:0] cal_focal    = FOCAL_RST;
  logic [19:0] cal_baseline = BASELINE_RST;
  logic [15:0] cal_u0       = U0_RST;
  logic [15:0] cal_v0       = V0_RST;
  logic [15:0] cal_min_disp = MIN_DISP_RST;
  logic [23:0] cal_depth_lim = DEPTH_LIM_RST;

  pixel_t      pixels_to_send[$];
  point_t      points_due[$];
  pixel_t      next_pixel;
  point_t      due;
  point_t      want;
  bit          word_taken = 1'b0;
  bit          bad;
  int          mismatches = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          cycle_cnt = 0;

  disparity_to_3d_reprojection_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_row    (pixel_row),
    .pixel_col    (pixel_col),
    .disparity_q4 (disparity_q4),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .out_row      (out_row),
    .out_col      (out_col)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Reproject one pixel with the current calibration. Returns 1 when the pixel
  // is kept, with the point in pt. All math is exact 64-bit signed; SystemVerilog
  // signed division truncates toward zero, which is what the core must do.
  function automatic bit reproject_pixel(input pixel_t px, output point_t pt);
    longint b, f, dd, lim, depth, off_x, off_y, r, c, u, v;
    pt = '0;
    b = longint'(cal_baseline);
    f = longint'(cal_focal);
    dd = longint'(px.disp);
    lim = longint'(cal_depth_lim);
    r = longint'(px.row);
    c = longint'(px.col);
    u = longint'(cal_u0);
    v = longint'(cal_v0);
    if (r >= IMG_ROWS || c >= IMG_COLS) return 1'b0;
    // Zero disparity always fails here, so the divide below never sees zero.
    if (px.disp <= cal_min_disp) return 1'b0;
    depth = (b * f) / dd;
    if (depth >= lim) return 1'b0;
    off_x = 16 * c - u;
    off_y = 16 * r - v;
    pt.x = 48'((off_x * b) / dd);
    pt.y = 48'(-((off_y * b) / dd));
    pt.z = 25'(-depth);
    pt.row = px.row;
    pt.col = px.col;
    return 1'b1;
  endfunction

  // Smallest disparity that passes both the minimum and the depth test;
  // above 65535 when no disparity can pass.
  function automatic longint keep_edge();
    longint bf, lim, e;
    bf = longint'(cal_baseline);
    bf = bf * longint'(cal_focal);
    lim = longint'(cal_depth_lim);
    if (lim == 0) return 65536;
    e = bf / lim + 1;
    if (e <= longint'(cal_min_disp)) e = longint'(cal_min_disp) + 1;
    return e;
  endfunction

  task automatic queue_pixel(input logic [11:0] r, input logic [11:0] c, input logic [15:0] d);
    pixel_t px;
    px.row = r;
    px.col = c;
    px.disp = d;
    pixels_to_send.insert(pixels_to_send.size(), px);
  endtask

  // Write one register and mirror it in the calibration copy.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_FOCAL:     cal_focal = data[15:0];
      REG_BASELINE:  cal_baseline = data[19:0];
      REG_U0:        cal_u0 = data[15:0];
      REG_V0:        cal_v0 = data[15:0];
      REG_MIN_DISP:  cal_min_disp = data[15:0];
      REG_DEPTH_LIM: cal_depth_lim = data[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Load a full calibration. Bits above each register's width carry junk so
  // that masking is exercised; a write to an unused index goes in first.
  task automatic set_calibration(input logic [15:0] f, input logic [19:0] b,
                                 input logic [15:0] u, input logic [15:0] v,
                                 input logic [15:0] m, input logic [23:0] l);
    logic [CFG_W-1:0] w;
    write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
    w = CFG_W'($urandom); w[15:0] = f; write_reg(REG_FOCAL, w);
    w = CFG_W'($urandom); w[19:0] = b; write_reg(REG_BASELINE, w);
    w = CFG_W'($urandom); w[15:0] = u; write_reg(REG_U0, w);
    w = CFG_W'($urandom); w[15:0] = v; write_reg(REG_V0, w);
    w = CFG_W'($urandom); w[15:0] = m; write_reg(REG_MIN_DISP, w);
    write_reg(REG_DEPTH_LIM, l);
  endtask

  // Random but plausible calibration: keep the limit loose enough that a good
  // share of disparities still produce points.
  task automatic random_calibration();
    logic [15:0] f, u, v, m;
    logic [19:0] b;
    logic [23:0] l;
    longint      fl, bl, ll;
    f = 16'($urandom_range(1, 65535));
    b = 20'($urandom_range(1, 1048575));
    u = 16'($urandom);
    v = 16'($urandom);
    m = 16'($urandom_range(0, 255));
    l = 24'($urandom);
    fl = longint'(f);
    bl = longint'(b);
    ll = longint'(l);
    if (ll == 0 || fl * bl / ll > 60000) l = 24'hFFFFFF;
    set_calibration(f, b, u, v, m, l);
  endtask

  // Mostly pixels that get kept, with random position and disparity; the rest
  // sit on the depth edge, on the minimum, or anywhere at all.
  task automatic add_random_pixels(input int n);
    longint      lo, t;
    logic [11:0] r, c;
    logic [15:0] d;
    lo = keep_edge();
    for (int i = 0; i < n; i++) begin
      r = 12'($urandom);
      c = 12'($urandom);
      d = 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if (lo <= 65535) d = 16'($urandom_range(lo, 65535));
        end
        4, 5: begin
          t = lo + $urandom_range(0, 255);
          if (t <= 65535) d = 16'(t);
        end
        6: begin
          t = lo + $urandom_range(0, 4) - 2;
          if (t >= 0 && t <= 65535) d = 16'(t);
        end
        7: begin
          t = cal_min_disp + $urandom_range(0, 2) - 1;
          if (t >= 0 && t <= 65535) d = 16'(t);
        end
        default: ;
      endcase
      queue_pixel(r, c, d);
    end
  endtask

  // Hold until every pixel is sent and every point has come out, then let the
  // pipeline drain dropped pixels before touching registers.
  task automatic wait_idle();
    while (pixels_to_send.size() != 0 || points_due.size() != 0 || in_valid)
      @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Input driver: bursts of words with random gaps, occasionally a long
  // unbroken run. Hold the word while the core stalls it.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !word_taken)) begin
      if (gap_left > 0 || pixels_to_send.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        next_pixel = pixels_to_send.pop_front();
        in_valid     <= 1'b1;
        pixel_row    <= next_pixel.row;
        pixel_col    <= next_pixel.col;
        disparity_q4 <= next_pixel.disp;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Output back-pressure: switch at random between stall patterns, holding each for a random stretch.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_TOGGLE: out_stall <= ~out_stall;
      default:      out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Monitor: check the output word first, then predict the accepted pixel.
  always @(posedge clk) begin
    if (rst) begin
      word_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word: x=%h y=%h z=%h row=%0d col=%0d",
                     point_x, point_y, point_z, out_row, out_col);
          mismatches++;
        end else begin
          want = points_due.pop_front();
          bad = (point_x !== want.x) || (point_y !== want.y) || (point_z !== want.z) ||
                (out_row !== want.row) || (out_col !== want.col);
          if (bad) begin
            if (mismatches < 10)
              $display("mismatch: exp %h %h %h %0d %0d, got %h %h %h %0d %0d",
                       want.x, want.y, want.z, want.row, want.col,
                       point_x, point_y, point_z, out_row, out_col);
            mismatches++;
          end
        end
      end
      word_taken = in_valid && !in_stall;
      if (word_taken && reproject_pixel({pixel_row, pixel_col, disparity_q4}, due))
        points_due.insert(points_due.size(), due);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    longint d_edge;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pixels under the reset calibration.
    d_edge = keep_edge();
    queue_pixel(12'd0, 12'd0, 16'd0);                       // zero disparity
    queue_pixel(12'd0, 12'd0, cal_min_disp);                // at the minimum: dropped
    queue_pixel(12'd4095, 12'd4095, 16'(cal_min_disp + 1)); // above minimum but too far
    queue_pixel(12'd300, 12'd600, 16'(d_edge - 1));         // depth at or past the limit
    queue_pixel(12'd300, 12'd600, 16'(d_edge));             // first kept disparity
    queue_pixel(12'd0, 12'd0, 16'(d_edge));
    queue_pixel(12'd4095, 12'd4095, 16'(d_edge));
    queue_pixel(12'd0, 12'd0, 16'hFFFF);
    queue_pixel(12'd4095, 12'd4095, 16'hFFFF);
    queue_pixel(12'd0, 12'd4095, 16'hFFFF);
    queue_pixel(12'd4095, 12'd0, 16'hFFFE);
    queue_pixel(12'd247, 12'd509, 16'd2000);           // just left of / above center
    queue_pixel(12'd248, 12'd510, 16'd2000);           // just right of / below center
    queue_pixel(12'hAAA, 12'h555, 16'hAAAA);
    queue_pixel(12'h555, 12'hAAA, 16'h5555);
    queue_pixel(12'hFFF, 12'h000, 16'h8000);
    queue_pixel(12'h000, 12'hFFF, 16'h7FFF);
    queue_pixel(12'd1, 12'd1, 16'd1);
    add_random_pixels(150);
    wait_idle();

    // Every other register at its top; a minimum of zero lets a disparity of one through
    // the minimum test.
    set_calibration(16'hFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 24'hFFFFFF);
    queue_pixel(12'd0, 12'd0, 16'd0);
    queue_pixel(12'd4095, 12'd4095, 16'd1);
    queue_pixel(12'd0, 12'd0, 16'hFFFF);
    add_random_pixels(220);
    wait_idle();

    // Focal, baseline and limit at one, the rest at zero: depth rounds to zero above a disparity of one.
    set_calibration(16'd1, 20'd1, 16'd0, 16'd0, 16'd0, 24'd1);
    queue_pixel(12'd4095, 12'd4095, 16'd1);
    queue_pixel(12'd4095, 12'd4095, 16'd2);
    queue_pixel(12'd0, 12'd0, 16'hFFFF);
    add_random_pixels(200);
    wait_idle();

    // Zero depth limit: nothing may come out.
    set_calibration(16'($urandom_range(1, 65535)), 20'($urandom_range(1, 1048575)),
                    16'($urandom), 16'($urandom), 16'd0, 24'd0);
    add_random_pixels(30);
    wait_idle();

    // Minimum at the top: no disparity can exceed it.
    set_calibration(16'($urandom_range(1, 65535)), 20'($urandom_range(1, 1048575)),
                    16'($urandom), 16'($urandom), 16'hFFFF, 24'hFFFFFF);
    queue_pixel(12'd100, 12'd100, 16'hFFFF);
    add_random_pixels(30);
    wait_idle();

    // Zero focal length, then zero baseline: depth is zero and points are kept.
    set_calibration(16'd0, 20'($urandom_range(1, 1048575)), 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, 64)), 24'($urandom_range(1, 16777215)));
    add_random_pixels(50);
    wait_idle();
    set_calibration(16'($urandom_range(1, 65535)), 20'd0, 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, 64)), 24'($urandom_range(1, 16777215)));
    add_random_pixels(50);
    wait_idle();

    for (int k = 0; k < 4; k++) begin
      random_calibration();
      add_random_pixels(200);
      wait_idle();
    end

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### files.f
rtl/dr3d_pkg.sv
rtl/dr3d_pipe.sv
rtl/dr3d_front.sv
rtl/dr3d_div.sv
rtl/dr3d_back.sv
rtl/disparity_to_3d_reprojection_core.sv
tb/tb.sv
